// ----- sv/aebd_pkg.sv -----
// aebd_pkg: shared constants, state and select types of the beat detector
// no dependencies; imported by the channel interfaces, the divider and the top level
package aebd_pkg;

    // default sizing of the top level
    localparam int HISTORY_DEPTH_DEF     = 43;
    localparam int MAX_BLOCK_SAMPLES_DEF = 4096;

    // fixed field widths
    localparam int SAMPLE_W = 16;
    localparam int TIME_W   = 32;
    localparam int REFR_W   = 16;
    localparam int ENERGY_W = 31;
    localparam int LEVEL_W  = 8;

    // level scaling, clamping and beat threshold
    localparam int LEVEL_SCALE = 150;
    localparam int LEVEL_MIN   = 55;
    localparam int LEVEL_MAX   = 240;
    localparam int BEAT_DIV    = 5;
    localparam int REFR_RESET  = 150;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ACC,
        ST_E_START,
        ST_E_WAIT,
        ST_UPDATE,
        ST_A_START,
        ST_A_WAIT,
        ST_SCALE,
        ST_R_START,
        ST_R_WAIT,
        ST_EMIT
    } aebd_state_t;

    // operand selection of the shared divider
    typedef enum logic [1:0] {
        DIV_SEL_MEAN,
        DIV_SEL_AVG,
        DIV_SEL_RATIO
    } aebd_div_sel_t;

    // operand selection of the shared multiplier
    typedef enum logic {
        MUL_SEL_SQUARE,
        MUL_SEL_SCALE
    } aebd_mul_sel_t;

    // divider status seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } aebd_div_status_t;

endpackage

// ----- sv/aebd_channels_if.sv -----
// aebd channel interfaces: sample request, result request and config write
// depends on aebd_pkg for the field widths
interface aebd_sample_if import aebd_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_in_block;
    logic [TIME_W-1:0]          now_ms;

    modport source (output valid, sample, last_in_block, now_ms, input ready);
    modport sink   (input valid, sample, last_in_block, now_ms, output ready);
endinterface

interface aebd_result_if import aebd_pkg::*;;
    logic                valid;
    logic                ready;
    logic [ENERGY_W-1:0] mean_energy;
    logic [LEVEL_W-1:0]  energy_level;
    logic                level_valid;
    logic                beat;
    logic                block_overflow;

    modport source (output valid, mean_energy, energy_level, level_valid, beat,
                    block_overflow, input ready);
    modport sink   (input valid, mean_energy, energy_level, level_valid, beat,
                    block_overflow, output ready);
endinterface

interface aebd_cfg_if import aebd_pkg::*;;
    logic              valid;
    logic              ready;
    logic [REFR_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ----- sv/aebd_div.sv -----
// aebd_div: shared restoring divider, one quotient bit per cycle
// depends on aebd_pkg for the status struct
module aebd_div import aebd_pkg::*; #(
    parameter int W = 48
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [W-1:0]     dividend,
    input  logic [W-1:0]     divisor,
    output logic [W-1:0]     quotient,
    output aebd_div_status_t status
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  rem_reg;
    logic [W-1:0]  quo_reg;
    logic [W-1:0]  den_reg;
    logic [CW-1:0] step_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [W:0]    shifted;
    logic [W:0]    trial;
    logic          fits;

    // one trial subtraction per step
    assign shifted = {rem_reg, quo_reg[W-1]};
    assign trial   = shifted - {1'b0, den_reg};
    assign fits    = ~trial[W];

    // control of the iteration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + CW'(1);
            if (step_reg == CW'(W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // remainder and quotient shift register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? trial[W-1:0] : shifted[W-1:0];
            quo_reg <= {quo_reg[W-2:0], fits};
        end
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ----- sv/audio_energy_beat_detector_unit.sv -----
// audio_energy_beat_detector_unit: sound energy beat detector top level
// depends on aebd_pkg, the aebd channel interfaces and aebd_div
//
// samples: one request per PCM sample, last_in_block marks the end of a block.
// A sample that is not the last passes through accept, square on the
// shared multiplier and accumulate; samples.ready is low in between.
// The last sample of a block starts three divisions on the shared restoring
// divider (mean, history average, level ratio), one after the other, before
// the result is loaded; DIV_W is 43 at the default sizing. The beat threshold
// is compared as 5e > 6avg with shifts and adds, and a zero average skips
// the ratio.
// results: one request per block with mean energy, level, beat and overflow.
// The result sits in an output register; a new block may be accumulated while
// it waits, and only the next block end stalls until results.ready takes it.
// cfg: writes refractory_ms, always ready; write only while the block is idle.
// Reset clears the sums, the history fill and position, the last beat time
// and the result valid, and sets refractory_ms to 150. The history memory is
// not cleared: entries at or above the fill count read as zero.
module audio_energy_beat_detector_unit import aebd_pkg::*; #(
    parameter int HISTORY_DEPTH     = HISTORY_DEPTH_DEF,
    parameter int MAX_BLOCK_SAMPLES = MAX_BLOCK_SAMPLES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    aebd_sample_if.sink    samples,
    aebd_result_if.source  results,
    aebd_cfg_if.sink       cfg
);

    localparam int POS_W  = $clog2(HISTORY_DEPTH);
    localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
    localparam int CNT_W  = $clog2(MAX_BLOCK_SAMPLES + 1);
    localparam int SUM_W  = 30 + CNT_W;
    localparam int TOT_W  = ENERGY_W + FILL_W;
    localparam int PROD_W = ENERGY_W + SAMPLE_W;
    localparam int SCL_W  = ENERGY_W + LEVEL_W;
    localparam int CMP_W  = TOT_W + 3;
    localparam int DIV_W0 = (SUM_W > TOT_W) ? SUM_W : TOT_W;
    localparam int DIV_W  = (DIV_W0 > SCL_W) ? DIV_W0 : SCL_W;

    aebd_state_t   state_reg, state_next;
    aebd_div_sel_t div_sel;
    aebd_mul_sel_t mul_sel;
    logic          div_start;
    logic          take_sample;
    logic          emit_load;

    logic [SAMPLE_W-1:0] mag_reg;
    logic                last_reg;
    logic                acc_en_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [CNT_W-1:0]    count_reg;
    logic                ovf_reg;

    logic [ENERGY_W-1:0] hist_mem [HISTORY_DEPTH];
    logic [ENERGY_W-1:0] old_reg;
    logic                old_valid_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [FILL_W-1:0]   fill_reg;
    logic [TOT_W-1:0]    total_reg;

    logic [ENERGY_W-1:0] e_reg;
    logic [TOT_W-1:0]    avg_reg;
    logic [LEVEL_W-1:0]  level_reg;
    logic                lvalid_reg;
    logic                beat_reg;
    logic [TIME_W-1:0]   last_beat_reg;
    logic [REFR_W-1:0]   refr_reg;

    logic                out_valid_reg, out_valid_next;
    logic [ENERGY_W-1:0] out_energy_reg;
    logic [LEVEL_W-1:0]  out_level_reg;
    logic                out_lvalid_reg;
    logic                out_beat_reg;
    logic                out_ovf_reg;

    logic [ENERGY_W-1:0] mul_a;
    logic [SAMPLE_W-1:0] mul_b;
    logic [DIV_W-1:0]    div_dividend;
    logic [DIV_W-1:0]    div_divisor;
    logic [DIV_W-1:0]    div_q;
    aebd_div_status_t    div_status;

    logic [ENERGY_W-1:0] old_eff;
    logic [CMP_W-1:0]    e_x5;
    logic [CMP_W-1:0]    avg_x6;
    logic                beat_hit;
    logic [TIME_W-1:0]   since_beat;
    logic                count_full;

    // shared divider
    aebd_div #(
        .W (DIV_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_q),
        .status   (div_status)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (take_sample) state_next = ST_SQUARE;
            ST_SQUARE:  state_next = ST_ACC;
            ST_ACC:     state_next = last_reg ? ST_E_START : ST_IDLE;
            ST_E_START: state_next = ST_E_WAIT;
            ST_E_WAIT:  if (div_status.done) state_next = ST_UPDATE;
            ST_UPDATE:  state_next = ST_A_START;
            ST_A_START: state_next = ST_A_WAIT;
            ST_A_WAIT:
            begin
                if (div_status.done)
                begin
                    state_next = (div_q == '0) ? ST_EMIT : ST_SCALE;
                end
            end
            ST_SCALE:   state_next = ST_R_START;
            ST_R_START: state_next = ST_R_WAIT;
            ST_R_WAIT:  if (div_status.done) state_next = ST_EMIT;
            ST_EMIT:    if (!out_valid_reg || results.ready) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        div_start = 1'b0;
        div_sel   = DIV_SEL_MEAN;
        mul_sel   = MUL_SEL_SQUARE;
        emit_load = 1'b0;
        samples.ready = 1'b0;
        case (state_reg)
            ST_IDLE:    samples.ready = 1'b1;
            ST_E_START: div_start = 1'b1;
            ST_A_START:
            begin
                div_start = 1'b1;
                div_sel   = DIV_SEL_AVG;
            end
            ST_SCALE:   mul_sel = MUL_SEL_SCALE;
            ST_R_START:
            begin
                div_start = 1'b1;
                div_sel   = DIV_SEL_RATIO;
            end
            ST_EMIT:    emit_load = !out_valid_reg || results.ready;
            default:    div_start = 1'b0;
        endcase
    end

    assign take_sample = samples.valid && samples.ready;
    assign count_full  = (count_reg == CNT_W'(MAX_BLOCK_SAMPLES));

    // shared multiplier operands
    always_comb
    begin
        case (mul_sel)
            MUL_SEL_SCALE:
            begin
                mul_a = e_reg;
                mul_b = SAMPLE_W'(LEVEL_SCALE);
            end
            default:
            begin
                mul_a = ENERGY_W'(mag_reg);
                mul_b = mag_reg;
            end
        endcase
    end

    // shared divider operands
    always_comb
    begin
        case (div_sel)
            DIV_SEL_AVG:
            begin
                div_dividend = DIV_W'(total_reg);
                div_divisor  = DIV_W'(fill_reg);
            end
            DIV_SEL_RATIO:
            begin
                div_dividend = DIV_W'(prod_reg);
                div_divisor  = DIV_W'(avg_reg);
            end
            default:
            begin
                div_dividend = DIV_W'(sum_reg);
                div_divisor  = DIV_W'(count_reg);
            end
        endcase
    end

    // replaced history entry, zero where never filled
    assign old_eff = old_valid_reg ? old_reg : '0;

    // e above avg + avg/5 is the same as 5e above 6avg
    assign e_x5       = (CMP_W'(e_reg) << 2) + CMP_W'(e_reg);
    assign avg_x6     = (CMP_W'(avg_reg) << 2) + (CMP_W'(avg_reg) << 1);
    assign since_beat = now_reg - last_beat_reg;
    assign beat_hit   = (e_x5 > avg_x6) && (since_beat > TIME_W'(refr_reg));

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sum_reg       <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            pos_reg       <= '0;
            fill_reg      <= '0;
            total_reg     <= '0;
            last_beat_reg <= '0;
            refr_reg      <= REFR_W'(REFR_RESET);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;

            // configuration write
            if (cfg.valid && cfg.ready)
            begin
                refr_reg <= cfg.data;
            end

            // overflow check at accept
            if (take_sample && count_full)
            begin
                ovf_reg <= 1'b1;
            end

            // accumulate the square
            if (state_reg == ST_ACC && acc_en_reg)
            begin
                sum_reg   <= sum_reg + SUM_W'(prod_reg);
                count_reg <= count_reg + CNT_W'(1);
            end

            // push the mean into the history
            if (state_reg == ST_UPDATE)
            begin
                total_reg <= total_reg - TOT_W'(old_eff) + TOT_W'(e_reg);
                pos_reg   <= (pos_reg == POS_W'(HISTORY_DEPTH - 1)) ? '0
                                                                    : pos_reg + POS_W'(1);
                if (fill_reg != FILL_W'(HISTORY_DEPTH))
                begin
                    fill_reg <= fill_reg + FILL_W'(1);
                end
            end

            // beat decision updates the last beat time
            if (state_reg == ST_R_WAIT && div_status.done && beat_hit)
            begin
                last_beat_reg <= now_reg;
            end

            // block end clears the accumulation
            if (emit_load)
            begin
                sum_reg   <= '0;
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
        end
    end

    // result valid
    always_comb
    begin
        if (emit_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (take_sample)
        begin
            mag_reg    <= samples.sample[SAMPLE_W-1] ? SAMPLE_W'(-samples.sample)
                                                     : SAMPLE_W'(samples.sample);
            last_reg   <= samples.last_in_block;
            now_reg    <= samples.now_ms;
            acc_en_reg <= !count_full;
        end

        if (state_reg == ST_SQUARE || state_reg == ST_SCALE)
        begin
            prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        end

        if (state_reg == ST_E_WAIT && div_status.done)
        begin
            e_reg <= (count_reg == '0) ? '0 : div_q[ENERGY_W-1:0];
        end

        if (state_reg == ST_A_WAIT && div_status.done)
        begin
            avg_reg    <= div_q[TOT_W-1:0];
            lvalid_reg <= (div_q != '0);
            level_reg  <= '0;
            beat_reg   <= 1'b0;
        end

        // clamp the level ratio and take the beat decision
        if (state_reg == ST_R_WAIT && div_status.done)
        begin
            if (div_q < DIV_W'(LEVEL_MIN))
            begin
                level_reg <= LEVEL_W'(LEVEL_MIN);
            end
            else if (div_q > DIV_W'(LEVEL_MAX))
            begin
                level_reg <= LEVEL_W'(LEVEL_MAX);
            end
            else
            begin
                level_reg <= div_q[LEVEL_W-1:0];
            end
            beat_reg <= beat_hit;
        end

        // output register
        if (emit_load)
        begin
            out_energy_reg <= e_reg;
            out_level_reg  <= level_reg;
            out_lvalid_reg <= lvalid_reg;
            out_beat_reg   <= beat_reg;
            out_ovf_reg    <= ovf_reg;
        end
    end

    // history memory with registered read
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_E_START)
        begin
            old_reg       <= hist_mem[pos_reg];
            old_valid_reg <= (FILL_W'(pos_reg) < fill_reg);
        end
        if (state_reg == ST_UPDATE)
        begin
            hist_mem[pos_reg] <= e_reg;
        end
    end

    assign cfg.ready              = 1'b1;
    assign results.valid          = out_valid_reg;
    assign results.mean_energy    = out_energy_reg;
    assign results.energy_level   = out_level_reg;
    assign results.level_valid    = out_lvalid_reg;
    assign results.beat           = out_beat_reg;
    assign results.block_overflow = out_ovf_reg;

    // history position stays inside the ring and fill never passes its depth
    a_hist_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg < POS_W'(HISTORY_DEPTH) && fill_reg <= FILL_W'(HISTORY_DEPTH))
        else $error("history position or fill out of range");

    // sample count never passes the block limit
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_BLOCK_SAMPLES))
        else $error("sample count beyond block limit");

    // a valid level is always clamped
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.level_valid |->
            results.energy_level >= LEVEL_W'(LEVEL_MIN)
            && results.energy_level <= LEVEL_W'(LEVEL_MAX))
        else $error("reported level outside clamp range");

    // without a level there is no beat and the level reads zero
    a_no_level: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && !results.level_valid |->
            !results.beat && results.energy_level == '0)
        else $error("beat or level reported with zero average");

    // loading a result restarts the block accumulation
    a_block_clear: assert property (@(posedge clk) disable iff (!rst_n)
        emit_load |=> count_reg == '0 && !ovf_reg && sum_reg == '0)
        else $error("block accumulation not cleared at block end");

endmodule
